>>> rtl/hrc_pkg.sv
// hrc_pkg: shared types, constants and the character decoder for the
// homopolymer read classifier. No dependencies.
`default_nettype none

package hrc_pkg;

   // read length limit and derived counter width
   localparam int MaxReadLen = 1024;
   localparam int LenWidth   = $clog2(MaxReadLen + 1);
   localparam int ReadLenW   = 11;
   localparam int ThrWidth   = 7;
   localparam int ProdWidth  = LenWidth + ThrWidth;
   localparam int NumBases   = 4;

   // threshold reset value and the scale of the share test
   localparam logic [ThrWidth-1:0] ThrReset = 7'd89;
   localparam logic [ThrWidth-1:0] Hundred  = 7'd100;

   // base codes, order of the run cycle
   localparam logic [1:0] BaseT = 2'd0;
   localparam logic [1:0] BaseA = 2'd1;
   localparam logic [1:0] BaseC = 2'd2;
   localparam logic [1:0] BaseG = 2'd3;

   // ascii characters
   localparam logic [7:0] CharT = 8'h54;
   localparam logic [7:0] CharA = 8'h41;
   localparam logic [7:0] CharC = 8'h43;
   localparam logic [7:0] CharG = 8'h47;
   localparam logic [7:0] CharN = 8'h4E;

   typedef struct packed {
      logic [7:0] base_char;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                is_simple;
      logic [1:0]          simple_base;
      logic [ReadLenW-1:0] read_length;
      logic                invalid_char;
      logic                too_long;
   } rsp_type;

   typedef struct packed {
      logic [1:0] code;
      logic       is_n;
      logic       is_bad;
   } decoded_type;

   // read totals after closing the open run
   typedef struct packed {
      logic [NumBases-1:0][LenWidth-1:0] longest;
      logic [LenWidth-1:0]               length;
      logic                              invalid;
      logic                              overflow;
   } summary_type;

   function automatic decoded_type decode_char(input logic [7:0] ch);
      decoded_type d;
      d = '{code: BaseT, is_n: 1'b0, is_bad: 1'b0};
      case (ch)
         CharT: d.code = BaseT;
         CharA: d.code = BaseA;
         CharC: d.code = BaseC;
         CharG: d.code = BaseG;
         CharN: d.is_n = 1'b1;
         default: d.is_bad = 1'b1;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> rtl/hrc_run_tracker.sv
// hrc_run_tracker: per-read run state, longest runs per base and length count.
// Depends on hrc_pkg.
`default_nettype none

module hrc_run_tracker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire hrc_pkg::req_type     item,
   output hrc_pkg::summary_type      summary
);

   localparam logic [hrc_pkg::LenWidth-1:0] MaxLen =
      hrc_pkg::LenWidth'(hrc_pkg::MaxReadLen);

   logic [1:0]                                           phase_ff, phase_in;
   logic [hrc_pkg::LenWidth-1:0]                         run_ff, run_in;
   logic [hrc_pkg::NumBases-1:0][hrc_pkg::LenWidth-1:0]  longest_ff, longest_in;
   logic [hrc_pkg::NumBases-1:0][hrc_pkg::LenWidth-1:0]  closed;
   logic [hrc_pkg::LenWidth-1:0]                         len_ff, len_in;
   logic                                                 inv_ff, inv_in;
   logic                                                 ovf_ff, ovf_in;
   hrc_pkg::decoded_type                                 dec;

   // next state for one character
   always_comb begin
      dec        = hrc_pkg::decode_char(item.base_char);
      phase_in   = phase_ff;
      run_in     = run_ff;
      longest_in = longest_ff;
      len_in     = len_ff;
      inv_in     = inv_ff;
      ovf_in     = ovf_ff;

      // saturating length
      if (len_ff >= MaxLen) begin
         ovf_in = 1'b1;
      end else begin
         len_in = len_ff + 1'b1;
      end

      // run update
      if (dec.is_bad) begin
         inv_in = 1'b1;
      end else if (dec.is_n || (dec.code == phase_ff)) begin
         if (run_ff < MaxLen) begin
            run_in = run_ff + 1'b1;
         end
      end else begin
         if (run_ff > longest_ff[phase_ff]) begin
            longest_in[phase_ff] = run_ff;
         end
         phase_in = dec.code;
         run_in   = hrc_pkg::LenWidth'(1);
      end

      // close the open run for the end-of-read report
      closed = longest_in;
      if (run_in > longest_in[phase_in]) begin
         closed[phase_in] = run_in;
      end

      summary.longest  = closed;
      summary.length   = len_in;
      summary.invalid  = inv_in;
      summary.overflow = ovf_in;
   end

   // state registers, cleared at the end of each read
   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         phase_ff   <= hrc_pkg::BaseT;
         run_ff     <= '0;
         longest_ff <= '0;
         len_ff     <= '0;
         inv_ff     <= 1'b0;
         ovf_ff     <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         run_ff     <= run_in;
         longest_ff <= longest_in;
         len_ff     <= len_in;
         inv_ff     <= inv_in;
         ovf_ff     <= ovf_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/hrc_judge.sv
// hrc_judge: share test of the longest runs against the threshold, result build.
// Depends on hrc_pkg.
`default_nettype none

module hrc_judge (
   input  wire hrc_pkg::summary_type           summary,
   input  wire logic [hrc_pkg::ThrWidth-1:0]   threshold,
   output hrc_pkg::rsp_type                    result
);

   logic [hrc_pkg::ProdWidth-1:0]                        limit;
   logic [hrc_pkg::NumBases-1:0][hrc_pkg::ProdWidth-1:0] scaled;
   logic [hrc_pkg::NumBases-1:0]                         over;

   // threshold times length, and 100 times each longest run
   always_comb begin
      limit = hrc_pkg::ProdWidth'(threshold) * hrc_pkg::ProdWidth'(summary.length);
      for (int i = 0; i < hrc_pkg::NumBases; i++) begin
         scaled[i] = hrc_pkg::ProdWidth'(summary.longest[i])
                     * hrc_pkg::ProdWidth'(hrc_pkg::Hundred);
         over[i]   = scaled[i] > limit;
      end
   end

   // priority A, C, G, T; an invalid character blocks the test
   always_comb begin
      result.is_simple    = 1'b0;
      result.simple_base  = hrc_pkg::BaseT;
      result.read_length  = hrc_pkg::ReadLenW'(summary.length);
      result.invalid_char = summary.invalid;
      result.too_long     = summary.overflow;
      if (!summary.invalid) begin
         if (over[hrc_pkg::BaseA]) begin
            result.is_simple   = 1'b1;
            result.simple_base = hrc_pkg::BaseA;
         end else if (over[hrc_pkg::BaseC]) begin
            result.is_simple   = 1'b1;
            result.simple_base = hrc_pkg::BaseC;
         end else if (over[hrc_pkg::BaseG]) begin
            result.is_simple   = 1'b1;
            result.simple_base = hrc_pkg::BaseG;
         end else if (over[hrc_pkg::BaseT]) begin
            result.is_simple   = 1'b1;
            result.simple_base = hrc_pkg::BaseT;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/homopolymer_read_classifier_top.sv
// homopolymer_read_classifier_top: input register, run tracker, share test and
// result register. Depends on hrc_pkg, hrc_run_tracker and hrc_judge.
//
// Usage: one ASCII read character per req beat, last set on the final one.
// A read ending beat yields one rsp beat with the simple flag, the firing
// base, the saturated length and the invalid and too-long flags; other beats
// yield nothing. The threshold in hundredths is written through csr_; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset sets it to 89. Throughput: one character per cycle, sustained, while no
// read end waits on a stalled result, set by the run update between the input
// register and the state registers. A last character's verdict passes the
// input register, then the result register, on its way to rsp.
// Reset clears all read state and both registers' valid flags, and returns
// the threshold to 89.
// When the receiver stalls, the result register holds; further characters
// keep flowing until a second read end reaches the input register, which
// then waits and drops req_ready until the pending result is taken.
`default_nettype none

module homopolymer_read_classifier_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire hrc_pkg::req_type                req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output hrc_pkg::rsp_type                     rsp_payload,
   input  wire logic                            csr_write_enable,
   input  wire logic [hrc_pkg::ThrWidth-1:0]    csr_write_data
);

   logic                           thr_write;
   logic [hrc_pkg::ThrWidth-1:0]   threshold_ff;
   logic                           s1_valid_ff, s1_valid_in;
   hrc_pkg::req_type               s1_ff;
   logic                           s1_fire;
   logic                           rsp_valid_ff, rsp_valid_in;
   hrc_pkg::rsp_type               rsp_ff;
   hrc_pkg::summary_type           summary;
   hrc_pkg::rsp_type               result;

   assign thr_write = csr_write_enable;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= hrc_pkg::ThrReset;
      end else if (thr_write) begin
         threshold_ff <= csr_write_data;
      end
   end

   // input stage advances unless a read end meets a full, stalled result
   assign s1_fire   = s1_valid_ff && (!s1_ff.last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_payload;
      end
   end

   // run state
   hrc_run_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (s1_fire),
      .item    (s1_ff),
      .summary (summary)
   );

   // share test
   hrc_judge u_judge (
      .summary   (summary),
      .threshold (threshold_ff),
      .result    (result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_ff.last) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> bench/hrc_read_checker.sv
// hrc_read_checker: watches the req, rsp and csr ports of the homopolymer read
// classifier, predicts each read verdict and compares it with the rsp beats.
// Depends on hrc_pkg for the payload types, base codes and ascii characters.

module hrc_read_checker
   import hrc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire req_type              req_payload,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire rsp_type              rsp_payload,
   input  wire logic                 csr_write_enable,
   input  wire logic [ThrWidth-1:0]  csr_write_data,
   output int                        outstanding,
   output int                        failures
);
   timeunit 1ns;
   timeprecision 1ps;

   // predicted read state
   logic [1:0]          cur_base;
   int                  run_len;
   int                  longest_run_len [NumBases];
   int                  read_len;
   bit                  saw_invalid;
   bit                  saw_overflow;
   logic [ThrWidth-1:0] share_threshold;

   // verdicts predicted but not yet seen on rsp
   rsp_type             verdict_q [$];

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t: read verdict mismatch on %s: got %0d, want %0d", $realtime, field, got,
               want);
      failures++;
   endtask

   task automatic start_new_read();
      cur_base     = BaseT;
      run_len      = 0;
      read_len     = 0;
      saw_invalid  = 1'b0;
      saw_overflow = 1'b0;
      for (int i = 0; i < NumBases; i++) longest_run_len[i] = 0;
   endtask

   // fold the open run into its base's longest run
   task automatic fold_run();
      if (run_len > longest_run_len[cur_base]) longest_run_len[cur_base] = run_len;
   endtask

   task automatic absorb_char(input req_type beat);
      logic [1:0] code;
      logic [1:0] probe;
      bit         is_n;
      bit         is_bad;
      int         limit;
      rsp_type    verdict;

      code   = BaseT;
      is_n   = 1'b0;
      is_bad = 1'b0;
      case (beat.base_char)
         CharT: code = BaseT;
         CharA: code = BaseA;
         CharC: code = BaseC;
         CharG: code = BaseG;
         CharN: is_n = 1'b1;
         default: is_bad = 1'b1;
      endcase

      // length saturates and remembers the overflow
      if (read_len >= MaxReadLen) begin
         saw_overflow = 1'b1;
      end else begin
         read_len++;
      end

      // run tracking: N or the same base extends, another base restarts
      if (is_bad) begin
         saw_invalid = 1'b1;
      end else if (is_n || code == cur_base) begin
         if (run_len < MaxReadLen) run_len++;
      end else begin
         fold_run();
         cur_base = code;
         run_len  = 1;
      end

      if (beat.last) begin
         fold_run();
         verdict = '0;
         if (!saw_invalid) begin
            limit = int'(share_threshold) * read_len;
            // search order A, C, G, T is the base code plus one, wrapping
            for (int i = 0; i < NumBases; i++) begin
               probe = 2'(i + 1);
               if (!verdict.is_simple && 100 * longest_run_len[probe] > limit) begin
                  verdict.is_simple   = 1'b1;
                  verdict.simple_base = probe;
               end
            end
         end
         verdict.read_length  = ReadLenW'(read_len);
         verdict.invalid_char = saw_invalid;
         verdict.too_long     = saw_overflow;
         verdict_q = {verdict_q, verdict};
         start_new_read();
      end
   endtask

   // sample all three ports on the rising edge, results before characters
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         start_new_read();
         share_threshold = ThrReset;
         verdict_q.delete();
      end else begin
         if (csr_write_enable) share_threshold = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (verdict_q.size() == 0) begin
               $display("%0t: rsp beat with no read verdict pending", $realtime);
               failures++;
            end else begin
               want = verdict_q.pop_front();
               if (got.is_simple !== want.is_simple)
                  report_mismatch("is_simple", got.is_simple, want.is_simple);
               if (got.simple_base !== want.simple_base)
                  report_mismatch("simple_base", got.simple_base, want.simple_base);
               if (got.read_length !== want.read_length)
                  report_mismatch("read_length", got.read_length, want.read_length);
               if (got.invalid_char !== want.invalid_char)
                  report_mismatch("invalid_char", got.invalid_char, want.invalid_char);
               if (got.too_long !== want.too_long)
                  report_mismatch("too_long", got.too_long, want.too_long);
            end
         end
         if (req_valid && req_ready) absorb_char(req_payload);
      end
      outstanding <= verdict_q.size();
   end

endmodule

>>> bench/tb_homopolymer_read_classifier_top.sv
// tb_homopolymer_read_classifier_top: drives reads, threshold writes and rsp
// back-pressure into the classifier and gives the verdict.
// Depends on hrc_pkg, homopolymer_read_classifier_top and hrc_read_checker.

module tb_homopolymer_read_classifier_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hrc_pkg::*;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   req_type             req_payload      = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_write_enable = 1'b0;
   logic [ThrWidth-1:0] csr_write_data   = '0;

   int                  outstanding;
   int                  failures;

   // chance in a hundred of an idle cycle on each side
   int                  idle_pct  = 26;
   int                  stall_pct = 26;
   int                  beats_sent;

   always #10 clock = ~clock;

   homopolymer_read_classifier_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   hrc_read_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .outstanding      (outstanding),
      .failures         (failures)
   );

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic logic [7:0] base_char_of(input int k);
      case (k)
         0: return CharT;
         1: return CharA;
         2: return CharC;
         default: return CharG;
      endcase
   endfunction

   // one character beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [7:0] ch, input logic fin);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{base_char: ch, last: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
   endtask

   // a read built from base runs, with some N and some noise bytes
   task automatic send_read(input int len, input int noise_pct, input int min_run,
                            input int max_run);
      logic [7:0] run_char;
      logic [7:0] ch;
      int         run_left;
      run_left = 0;
      run_char = CharT;
      for (int i = 0; i < len; i++) begin
         if (run_left == 0) begin
            run_char = base_char_of($urandom_range(3));
            run_left = $urandom_range(max_run, min_run);
         end
         ch = run_char;
         if ($urandom_range(99) < noise_pct) begin
            ch = 8'($urandom_range(255));
         end else if ($urandom_range(99) < 5) begin
            ch = CharN;
         end
         send_beat(ch, i == len - 1);
         run_left--;
      end
   endtask

   // wait for every verdict, then the pipeline latency
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_share_threshold(input logic [ThrWidth-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int phase_start;
      int noise;
      int cap;
      logic [ThrWidth-1:0] thr;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed reads at the reset threshold
      send_text("A");
      send_text("T");
      send_text("NNNN");
      send_text("TACGN");
      send_beat(8'h00, 1'b0);
      send_beat(CharA, 1'b1);
      send_beat(8'hFF, 1'b1);

      // half share: an exact tie is not simple, a clear majority is
      set_share_threshold(7'd50);
      send_text("AACC");
      send_text("GTTT");

      // zero share: the first base in search order wins
      set_share_threshold(7'd0);
      send_text("CA");

      // random phases over a range of thresholds
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: thr = 7'd0;
            1: thr = 7'd100;
            2: thr = 7'd127;
            3: thr = ThrReset;
            6: thr = 7'd1;
            default: thr = 7'($urandom_range(100));
         endcase
         set_share_threshold(thr);

         // one phase runs with both sides always ready
         if (phase == 3) begin
            idle_pct  = 0;
            stall_pct = 0;
         end

         phase_start = beats_sent;
         while (beats_sent - phase_start < 90) begin
            noise = ($urandom_range(99) < 20) ? 30 : 0;
            cap   = $urandom_range(24, 1);
            send_read(cap, noise, 1, $urandom_range(cap, 1));
         end

         idle_pct  = 26;
         stall_pct = 26;
      end

      drain_results();
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // run limit
   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
